/* src/x86a_pkg.sv */
package x86a_pkg;

    // operation codes
    localparam logic [3:0] K_ADD = 4'd0;
    localparam logic [3:0] K_SUB = 4'd1;
    localparam logic [3:0] K_CMP = 4'd2;
    localparam logic [3:0] K_INC = 4'd3;
    localparam logic [3:0] K_DEC = 4'd4;
    localparam logic [3:0] K_NEG = 4'd5;
    localparam logic [3:0] K_AND = 4'd6;
    localparam logic [3:0] K_OR  = 4'd7;
    localparam logic [3:0] K_XOR = 4'd8;
    localparam logic [3:0] K_MUL = 4'd9;
    localparam logic [3:0] K_SAL = 4'd10;
    localparam logic [3:0] K_SAR = 4'd11;
    localparam logic [3:0] K_SHR = 4'd12;

    typedef struct packed {
        logic of;
        logic sf;
        logic zf;
        logic af;
        logic pf;
        logic cf;
    } t_flags;

    typedef struct packed {
        logic [3:0]  kind;
        logic        is_word;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [4:0]  shift_count;
    } t_op;

    typedef struct packed {
        logic [15:0] result;
        logic [15:0] result_high;
        logic        write_back;
        t_flags      flags;
    } t_res;

endpackage

/* src/x86a_in_if.sv */
interface x86a_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic        is_word;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [4:0]  shift_count;

    modport source (
        output valid, kind, is_word, operand_a, operand_b, shift_count,
        input  ready
    );
    modport sink (
        input  valid, kind, is_word, operand_a, operand_b, shift_count,
        output ready
    );
endinterface

/* src/x86a_out_if.sv */
interface x86a_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] result;
    logic [15:0] result_high;
    logic        write_back;
    logic        carry_flag;
    logic        parity_flag;
    logic        aux_flag;
    logic        zero_flag;
    logic        sign_flag;
    logic        overflow_flag;

    modport source (
        output valid, result, result_high, write_back, carry_flag, parity_flag,
               aux_flag, zero_flag, sign_flag, overflow_flag,
        input  ready
    );
    modport sink (
        input  valid, result, result_high, write_back, carry_flag, parity_flag,
               aux_flag, zero_flag, sign_flag, overflow_flag,
        output ready
    );
endinterface

/* src/x86_16bit_alu_with_flags_core.sv */
// a result beat passes the operand register and then the result register before it
// is offered, and waits in the operand register while the result register is full and not drained
// throughput: one beat per cycle while the receiver keeps taking results
// an input register feeds the alu; the result register and flags load together
// reset (i_rst_n low, synchronous) empties both stages and clears all six flags
module x86_16bit_alu_with_flags_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    x86a_in_if.sink           i_in,
    x86a_out_if.source        o_out
);
    import x86a_pkg::*;

    // operand stage
    logic   r_s1_valid;
    logic   n_s1_valid;
    t_op    r_s1_op;

    // result stage and architectural flags
    logic   r_out_valid;
    logic   n_out_valid;
    t_res   r_out;
    t_flags r_flags;
    t_flags n_flags;

    // handshake helpers
    t_res   w_res;
    logic   w_out_free;
    logic   w_adv;
    logic   w_in_take;

    // the result register can take a beat when empty or being drained this cycle
    assign w_out_free = !r_out_valid || o_out.ready;
    // operand stage moves into the result register
    assign w_adv      = r_s1_valid && w_out_free;
    // operand stage can refill whenever it is empty or moving on
    assign i_in.ready = !r_s1_valid || w_out_free;
    assign w_in_take  = i_in.valid && i_in.ready;

    // alu works on the registered operands and the current flags
    x86a_alu u_alu (
        .i_op    (r_s1_op),
        .i_flags (r_flags),
        .o_res   (w_res)
    );

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (w_in_take) begin
            n_s1_valid = 1'b1;
        end else if (w_adv) begin
            n_s1_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (w_adv) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        // flags only change when a beat leaves the alu, so back-to-back beats
        // see the flags of the one just before
        n_flags = w_adv ? w_res.flags : r_flags;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            r_flags     <= n_flags;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1_op.kind        <= i_in.kind;
            r_s1_op.is_word     <= i_in.is_word;
            r_s1_op.operand_a   <= i_in.operand_a;
            r_s1_op.operand_b   <= i_in.operand_b;
            r_s1_op.shift_count <= i_in.shift_count;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.result        = r_out.result;
    assign o_out.result_high   = r_out.result_high;
    assign o_out.write_back    = r_out.write_back;
    assign o_out.carry_flag    = r_out.flags.cf;
    assign o_out.parity_flag   = r_out.flags.pf;
    assign o_out.aux_flag      = r_out.flags.af;
    assign o_out.zero_flag     = r_out.flags.zf;
    assign o_out.sign_flag     = r_out.flags.sf;
    assign o_out.overflow_flag = r_out.flags.of;

    // flags must not move unless a beat passes into the result register
    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_flags))
        else $error("flags changed with no beat completing");

    // flags shown with a result are the ones kept for the next beat
    a_flags_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> ({o_out.overflow_flag, o_out.sign_flag, o_out.zero_flag,
                    o_out.aux_flag, o_out.parity_flag, o_out.carry_flag} == r_flags))
        else $error("result flags differ from stored flags");

    // compare never writes back
    a_cmp_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_s1_op.kind == K_CMP) |=> !o_out.write_back)
        else $error("compare marked for write back");

    // high half is only used by a word multiply
    a_high_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !(r_s1_op.kind == K_MUL && r_s1_op.is_word))
        |=> (o_out.result_high == 16'd0))
        else $error("high half set outside word multiply");

    // byte operations other than multiply leave the upper byte clear
    a_byte_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !r_s1_op.is_word && r_s1_op.kind != K_MUL)
        |=> (o_out.result[15:8] == 8'd0))
        else $error("byte result has upper bits set");

endmodule

/* src/x86a_alu.sv */
module x86a_alu (
    input  x86a_pkg::t_op    i_op,
    input  x86a_pkg::t_flags i_flags,
    output x86a_pkg::t_res   o_res
);
    import x86a_pkg::*;

    logic [15:0] mask;
    logic [15:0] msb;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] s;
    logic [15:0] r;
    logic [15:0] hi;
    logic [16:0] sum;
    logic [16:0] dif;
    logic [31:0] prod;
    logic [47:0] sal_w;
    logic [47:0] sr_e;
    logic [47:0] sr_t;
    logic [4:0]  cnt_m1;
    logic        sgn;
    logic        sal_cf;
    logic        up;
    logic        wb;
    t_flags      f;

    // sign, zero and parity from the result within the width
    function automatic t_flags szp(t_flags fi, logic [15:0] rv, logic [15:0] mk,
                                   logic [15:0] mb);
        t_flags fo;
        fo    = fi;
        fo.pf = ~^rv[7:0];
        fo.zf = ((rv & mk) == 16'd0);
        fo.sf = |(rv & mb);
        return fo;
    endfunction

    always_comb begin
        mask = i_op.is_word ? 16'hffff : 16'h00ff;
        msb  = i_op.is_word ? 16'h8000 : 16'h0080;
        a    = i_op.operand_a & mask;
        b    = i_op.operand_b & mask;
        s    = (i_op.kind == K_INC || i_op.kind == K_DEC) ? 16'd1 : b;
        sum  = {1'b0, a} + {1'b0, s};
        dif  = {1'b0, a} - {1'b0, s};
        prod = 32'(a) * 32'(b);
        sgn  = |(a & msb);

        // left shift: the bit just above the width is the last one out
        sal_w  = {32'd0, a} << i_op.shift_count;
        sal_cf = i_op.is_word ? sal_w[16] : sal_w[8];

        // right shifts: shift by count-1, bit 0 is the carry, the rest the result
        sr_e   = {32'd0, a} | ((i_op.kind == K_SAR && sgn) ? {32'hffff_ffff, ~mask} : 48'd0);
        cnt_m1 = i_op.shift_count - 5'd1;
        sr_t   = sr_e >> cnt_m1;

        f  = i_flags;
        r  = a;
        hi = 16'd0;
        wb = 1'b1;
        up = 1'b0;

        unique case (i_op.kind) inside
            K_ADD, K_INC: begin
                r = sum[15:0] & mask;
                if (i_op.kind == K_ADD) begin
                    f.cf = i_op.is_word ? sum[16] : sum[8];
                end
                f.af = a[4] ^ s[4] ^ r[4];
                f.of = |(~(a ^ s) & (a ^ r) & msb);
                f    = szp(f, r, mask, msb);
            end
            K_SUB, K_CMP, K_DEC: begin
                r = dif[15:0] & mask;
                if (i_op.kind != K_DEC) begin
                    f.cf = dif[16];
                end
                f.af = a[4] ^ s[4] ^ r[4];
                f.of = |((a ^ s) & (a ^ r) & msb);
                f    = szp(f, r, mask, msb);
                if (i_op.kind == K_CMP) begin
                    wb = 1'b0;
                end
            end
            K_NEG: begin
                r    = (16'd0 - a) & mask;
                f.cf = |a;
                f.af = |a[3:0];
                f.of = (a == msb);
                f    = szp(f, r, mask, msb);
            end
            K_AND, K_OR, K_XOR: begin
                if (i_op.kind == K_AND) begin
                    r = a & b;
                end else if (i_op.kind == K_OR) begin
                    r = a | b;
                end else begin
                    r = a ^ b;
                end
                f.cf = 1'b0;
                f.of = 1'b0;
                f    = szp(f, r, mask, msb);
            end
            K_MUL: begin
                r    = prod[15:0];
                hi   = i_op.is_word ? prod[31:16] : 16'd0;
                up   = i_op.is_word ? |prod[31:16] : |prod[15:8];
                f.cf = up;
                f.of = up;
            end
            K_SAL, K_SAR, K_SHR: begin
                // a zero count leaves everything alone
                if (i_op.shift_count != 5'd0) begin
                    if (i_op.kind == K_SAL) begin
                        r    = sal_w[15:0] & mask;
                        f.cf = sal_cf;
                        if (i_op.shift_count == 5'd1) begin
                            f.of = (|(r & msb)) ^ sal_cf;
                        end
                    end else begin
                        r    = sr_t[16:1] & mask;
                        f.cf = sr_t[0];
                        if (i_op.shift_count == 5'd1) begin
                            f.of = (i_op.kind == K_SHR) && sgn;
                        end
                    end
                    f = szp(f, r, mask, msb);
                end
            end
            default: begin
                wb = 1'b0;
            end
        endcase

        o_res.result      = r;
        o_res.result_high = hi;
        o_res.write_back  = wb;
        o_res.flags       = f;
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import x86a_pkg::*;

    // kind codes the alu leaves unused: result is operand_a within the width, no write-back
    localparam logic [3:0] K_SPARE_FIRST = 4'd13;
    localparam logic [3:0] K_SPARE_LAST  = 4'd15;

    // cycles with no beat on either side before the run is abandoned
    localparam int unsigned STALL_LIMIT = 4000;
    // settling time after the last result, from the two-stage pipeline
    localparam int unsigned DRAIN_CYCLES = 8;

    // flag-tracking alu model plus the queue of results still owed by the block
    class alu_scoreboard;
        t_flags      flags;
        t_res        owed_q[$];
        int unsigned n_errors;

        function new();
            flags    = '0;
            n_errors = 0;
        endfunction

        // parity over the low byte only, zero and sign within the width
        function t_flags with_szp(t_flags f, logic [31:0] r, logic [31:0] mask,
                                  logic [31:0] msb);
            f.pf = ~^r[7:0];
            f.zf = ((r & mask) == 0);
            f.sf = ((r & msb) != 0);
            return f;
        endfunction

        function t_res alu_result(t_op op);
            t_res        res;
            t_flags      f;
            logic [31:0] mask, msb, a, b, s, r, hi, sum, p;
            logic [63:0] w, e;
            int unsigned width;
            logic        cf, up, wb;

            mask  = op.is_word ? 32'hFFFF : 32'hFF;
            msb   = op.is_word ? 32'h8000 : 32'h80;
            width = op.is_word ? 16 : 8;
            a     = {16'd0, op.operand_a} & mask;
            b     = {16'd0, op.operand_b} & mask;
            f     = flags;
            r     = a;
            hi    = '0;
            wb    = 1'b1;

            case (op.kind)
                K_ADD, K_INC: begin
                    // inc leaves the carry alone
                    s   = (op.kind == K_ADD) ? b : 32'd1;
                    sum = a + s;
                    r   = sum & mask;
                    if (op.kind == K_ADD)
                        f.cf = (sum > mask);
                    f.af = (((a & 32'hF) + (s & 32'hF)) > 32'hF);
                    f.of = (((~(a ^ s)) & (a ^ r) & msb) != 0);
                    f    = with_szp(f, r, mask, msb);
                end
                K_SUB, K_CMP, K_DEC: begin
                    s = (op.kind == K_DEC) ? 32'd1 : b;
                    r = (a - s) & mask;
                    if (op.kind != K_DEC)
                        f.cf = (a < s);
                    f.af = ((a & 32'hF) < (s & 32'hF));
                    f.of = (((a ^ s) & (a ^ r) & msb) != 0);
                    f    = with_szp(f, r, mask, msb);
                    if (op.kind == K_CMP)
                        wb = 1'b0;
                end
                K_NEG: begin
                    r    = (32'd0 - a) & mask;
                    f.cf = (a != 0);
                    f.af = ((a & 32'hF) != 0);
                    f.of = (a == msb);
                    f    = with_szp(f, r, mask, msb);
                end
                K_AND, K_OR, K_XOR: begin
                    r    = (op.kind == K_AND) ? (a & b) :
                           (op.kind == K_OR)  ? (a | b) : (a ^ b);
                    f.cf = 1'b0;
                    f.of = 1'b0;
                    f    = with_szp(f, r, mask, msb);
                end
                K_MUL: begin
                    // byte product fills the whole 16-bit result
                    p = a * b;
                    r = p & 32'hFFFF;
                    if (op.is_word) begin
                        hi = p >> 16;
                        up = (hi != 0);
                    end else begin
                        up = ((r & 32'hFF00) != 0);
                    end
                    f.cf = up;
                    f.of = up;
                end
                K_SAL, K_SAR, K_SHR: begin
                    // a zero count touches nothing; large counts are not masked
                    if (op.shift_count != 0) begin
                        if (op.kind == K_SAL) begin
                            w  = {32'd0, a} << op.shift_count;
                            cf = w[width];
                            r  = w[31:0] & mask;
                            if (op.shift_count == 1)
                                f.of = ((r & msb) != 0) ^ cf;
                        end else begin
                            e = {32'd0, a};
                            if (op.kind == K_SAR && (a & msb) != 0)
                                e = e | ~{32'd0, mask};
                            cf = e[op.shift_count - 5'd1];
                            w  = e >> op.shift_count;
                            r  = w[31:0] & mask;
                            if (op.shift_count == 1)
                                f.of = (op.kind == K_SHR) && ((a & msb) != 0);
                        end
                        f.cf = cf;
                        f    = with_szp(f, r, mask, msb);
                    end
                end
                default: begin
                    wb = 1'b0;
                end
            endcase

            flags           = f;
            res.result      = r[15:0];
            res.result_high = hi[15:0];
            res.write_back  = wb;
            res.flags       = f;
            return res;
        endfunction

        function void note_op(t_op op);
            owed_q.push_back(alu_result(op));
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
                n_errors++;
            end
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected result beat, expected none actual %h", $time, got);
                n_errors++;
                return;
            end
            want = owed_q.pop_front();
            compare_field("result", want.result, got.result);
            compare_field("result_high", want.result_high, got.result_high);
            compare_field("write_back", 16'(want.write_back), 16'(got.write_back));
            compare_field("carry_flag", 16'(want.flags.cf), 16'(got.flags.cf));
            compare_field("parity_flag", 16'(want.flags.pf), 16'(got.flags.pf));
            compare_field("aux_flag", 16'(want.flags.af), 16'(got.flags.af));
            compare_field("zero_flag", 16'(want.flags.zf), 16'(got.flags.zf));
            compare_field("sign_flag", 16'(want.flags.sf), 16'(got.flags.sf));
            compare_field("overflow_flag", 16'(want.flags.of), 16'(got.flags.of));
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    x86a_in_if   in_bus();
    x86a_out_if  out_bus();

    alu_scoreboard board;
    int unsigned   send_idle_pct = 0;
    int unsigned   recv_idle_pct = 0;
    int unsigned   stall_cycles  = 0;
    t_op           seen_op;
    t_res          seen_res;
    t_op           directed[$];

    x86_16bit_alu_with_flags_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic t_op make_op(logic [3:0] kind, logic is_word, logic [15:0] a,
                                    logic [15:0] b, logic [4:0] cnt);
        t_op op;
        op.kind        = kind;
        op.is_word     = is_word;
        op.operand_a   = a;
        op.operand_b   = b;
        op.shift_count = cnt;
        return op;
    endfunction

    // operands lean on the sign and carry boundaries, garbage kept in the upper byte
    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            4:       return {8'($urandom), 8'h80};
            5:       return {8'($urandom), 8'h7F};
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_op rand_op();
        logic [3:0] kind;
        logic [4:0] cnt;
        // a few unused kinds mixed in with the real operations
        if ($urandom_range(0, 99) < 4)
            kind = 4'($urandom_range(K_SPARE_FIRST, K_SPARE_LAST));
        else
            kind = 4'($urandom_range(K_ADD, K_SHR));
        // counts mostly around the byte and word widths, sometimes anything
        if ($urandom_range(0, 3) == 0)
            cnt = 5'($urandom_range(0, 31));
        else
            cnt = 5'($urandom_range(0, 17));
        return make_op(kind, 1'($urandom), pick_operand(), pick_operand(), cnt);
    endfunction

    // one beat onto the input channel, with random gaps before it
    task automatic send_op(input t_op op);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid       <= 1'b1;
        in_bus.kind        <= op.kind;
        in_bus.is_word     <= op.is_word;
        in_bus.operand_a   <= op.operand_a;
        in_bus.operand_b   <= op.operand_b;
        in_bus.shift_count <= op.shift_count;
        do @(posedge i_clk); while (!in_bus.ready);
    endtask

    task automatic send_random(input int unsigned count);
        repeat (count) send_op(rand_op());
    endtask

    // both channels observed at the same edge: inputs feed the model first
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_bus.valid && in_bus.ready) begin
                seen_op.kind        = in_bus.kind;
                seen_op.is_word     = in_bus.is_word;
                seen_op.operand_a   = in_bus.operand_a;
                seen_op.operand_b   = in_bus.operand_b;
                seen_op.shift_count = in_bus.shift_count;
                board.note_op(seen_op);
            end
            if (out_bus.valid && out_bus.ready) begin
                seen_res.result      = out_bus.result;
                seen_res.result_high = out_bus.result_high;
                seen_res.write_back  = out_bus.write_back;
                seen_res.flags.cf    = out_bus.carry_flag;
                seen_res.flags.pf    = out_bus.parity_flag;
                seen_res.flags.af    = out_bus.aux_flag;
                seen_res.flags.zf    = out_bus.zero_flag;
                seen_res.flags.sf    = out_bus.sign_flag;
                seen_res.flags.of    = out_bus.overflow_flag;
                board.check_result(seen_res);
            end
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
        out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // watchdog on forward progress
    initial begin
        do @(posedge i_clk); while (stall_cycles < STALL_LIMIT);
        $display("testbench: errors");
        $finish;
    end

    initial begin
        board = new();
        i_rst_n            <= 1'b0;
        in_bus.valid       <= 1'b0;
        in_bus.kind        <= K_ADD;
        in_bus.is_word     <= 1'b0;
        in_bus.operand_a   <= '0;
        in_bus.operand_b   <= '0;
        in_bus.shift_count <= '0;

        // boundary cases for every operation
        directed.push_back(make_op(K_ADD, 1'b1, 16'hFFFF, 16'h0001, 5'd0));
        directed.push_back(make_op(K_ADD, 1'b0, 16'hAB7F, 16'hCD01, 5'd0));
        directed.push_back(make_op(K_SUB, 1'b1, 16'h0000, 16'h0001, 5'd0));
        directed.push_back(make_op(K_CMP, 1'b1, 16'h8000, 16'h0001, 5'd0));
        directed.push_back(make_op(K_INC, 1'b0, 16'h12FF, 16'h0000, 5'd0));
        directed.push_back(make_op(K_DEC, 1'b1, 16'h8000, 16'h0000, 5'd0));
        directed.push_back(make_op(K_NEG, 1'b1, 16'h8000, 16'h0000, 5'd0));
        directed.push_back(make_op(K_NEG, 1'b0, 16'hFF00, 16'h0000, 5'd0));
        directed.push_back(make_op(K_AND, 1'b1, 16'hFFFF, 16'h0000, 5'd0));
        directed.push_back(make_op(K_OR,  1'b0, 16'hF00F, 16'h0FF0, 5'd0));
        directed.push_back(make_op(K_XOR, 1'b1, 16'h5555, 16'hAAAA, 5'd0));
        directed.push_back(make_op(K_MUL, 1'b1, 16'hFFFF, 16'hFFFF, 5'd0));
        directed.push_back(make_op(K_MUL, 1'b0, 16'h12FF, 16'h34FF, 5'd0));
        directed.push_back(make_op(K_MUL, 1'b0, 16'hFF02, 16'hFF03, 5'd0));
        directed.push_back(make_op(K_SAL, 1'b1, 16'h8001, 16'h0000, 5'd1));
        // zero count keeps every flag
        directed.push_back(make_op(K_SAL, 1'b0, 16'h0081, 16'h0000, 5'd0));
        // shift counts of one, of the full width and past it, then the unused kinds
        directed.push_back(make_op(K_SAL, 1'b0, 16'h00FF, 16'h0000, 5'd9));
        directed.push_back(make_op(K_SAR, 1'b1, 16'h8000, 16'h0000, 5'd31));
        directed.push_back(make_op(K_SAR, 1'b0, 16'h0080, 16'h0000, 5'd1));
        directed.push_back(make_op(K_SHR, 1'b1, 16'hFFFF, 16'h0000, 5'd1));
        directed.push_back(make_op(K_SHR, 1'b0, 16'h0080, 16'h0000, 5'd8));
        directed.push_back(make_op(K_SHR, 1'b1, 16'hFFFF, 16'h0000, 5'd17));
        for (int k = K_SPARE_FIRST; k <= K_SPARE_LAST; k++)
            directed.push_back(make_op(4'(k), k[0], 16'hABCD, 16'h1234, 5'd3));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender mostly busy, receiver often stalls
        send_idle_pct = 18;
        recv_idle_pct = 45;
        foreach (directed[i])
            send_op(directed[i]);
        send_random(333);

        // roles swapped
        send_idle_pct = 45;
        recv_idle_pct = 18;
        send_random(333);

        // back to back at full rate
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(334);
        in_bus.valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.n_errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

/* sim.f */
src/x86a_pkg.sv
src/x86a_in_if.sv
src/x86a_out_if.sv
src/x86a_alu.sv
src/x86_16bit_alu_with_flags_core.sv
tb/testbench.sv
